// File: rtl/ps2st_pkg.sv
// Shared types and constants for the set 2 scancode translator.
`default_nettype none
package ps2st_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned TABLE_AW = 8;
    localparam int unsigned TABLE_D  = 1 << TABLE_AW;

    localparam logic [BYTE_W-1:0] SC_RELEASE  = 8'hf0;
    localparam logic [BYTE_W-1:0] SC_EXTENDED = 8'he0;
    localparam logic [BYTE_W-1:0] SC_PAUSE    = 8'he1;
    localparam logic [BYTE_W-1:0] PAUSE_KEY   = 8'h88;
    localparam logic [BYTE_W-1:0] EXT_BIT     = 8'h80;

    localparam logic MODE_SCAN  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [1:0] {
        PAUSE_IDLE = 2'd0,
        PAUSE_KEY_NEXT = 2'd1,
        PAUSE_DROP = 2'd2
    } t_pause_phase;

    // Decoder result for the item being transferred in this cycle
    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] code;
        logic              pressed;
    } t_dec_result;

endpackage
`default_nettype wire

// File: rtl/ps2st_decoder.sv
// Prefix tracking and table address generation for received scancode bytes.
`default_nettype none
module ps2st_decoder
    import ps2st_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic              i_mode,
    input  wire logic [BYTE_W-1:0] i_scan_byte,
    output t_dec_result            o_result
);

    logic         r_release_pending, n_release_pending;
    logic         r_extended_pending, n_extended_pending;
    t_pause_phase r_pause_phase, n_pause_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_pending  <= 1'b0;
            r_extended_pending <= 1'b0;
            r_pause_phase      <= PAUSE_IDLE;
        end else if (i_fire && i_mode == MODE_SCAN) begin
            r_release_pending  <= n_release_pending;
            r_extended_pending <= n_extended_pending;
            r_pause_phase      <= n_pause_phase;
        end
    end

    always_comb begin
        logic [BYTE_W-1:0] code;
        code               = i_scan_byte;
        n_release_pending  = r_release_pending;
        n_extended_pending = r_extended_pending;
        n_pause_phase      = r_pause_phase;
        o_result.emit      = 1'b0;
        o_result.pressed   = ~r_release_pending;

        if (i_scan_byte == SC_RELEASE) begin
            n_release_pending = 1'b1;
        end else if (i_scan_byte == SC_EXTENDED) begin
            n_extended_pending = 1'b1;
        end else if (i_scan_byte == SC_PAUSE) begin
            n_pause_phase = PAUSE_DROP;
        end else if (r_pause_phase == PAUSE_DROP) begin
            // drop the first byte after the pause prefix, keep flags pending
            n_pause_phase = PAUSE_KEY_NEXT;
        end else begin
            if (r_pause_phase == PAUSE_KEY_NEXT) begin
                code = PAUSE_KEY;
            end
            if (r_extended_pending) begin
                code = code | EXT_BIT;
            end
            n_pause_phase      = PAUSE_IDLE;
            n_extended_pending = 1'b0;
            n_release_pending  = 1'b0;
            o_result.emit      = (i_mode == MODE_SCAN);
        end
        o_result.code = code;
    end

endmodule
`default_nettype wire

// File: rtl/ps2st_key_table.sv
// Translation table memory with per-entry valid bits cleared at reset.
`default_nettype none
module ps2st_key_table
    import ps2st_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_we,
    input  wire logic [TABLE_AW-1:0] i_waddr,
    input  wire logic [BYTE_W-1:0]   i_wdata,
    input  wire logic                i_re,
    input  wire logic [TABLE_AW-1:0] i_raddr,
    output logic      [BYTE_W-1:0]   o_rdata
);

    logic [BYTE_W-1:0]  r_mem [TABLE_D];
    logic [TABLE_D-1:0] r_entry_valid;
    logic [BYTE_W-1:0]  r_rd_data;
    logic               r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
            r_rd_hit      <= 1'b0;
        end else begin
            if (i_we) begin
                r_entry_valid[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_hit <= r_entry_valid[i_raddr];
            end
        end
    end

    // unwritten entries read as zero
    assign o_rdata = r_rd_hit ? r_rd_data : '0;

endmodule
`default_nettype wire

// File: rtl/ps2_scancode_translator.sv
// Top level: set 2 scancode bytes in, translated key events out.
//
// Input stream: each transfer carries either a received keyboard byte
// (tuser = 0) or a translation table write (tuser = 1). Prefix bytes F0
// (release), E0 (extended) and E1 (pause) and the dropped byte after E1
// give no event; every other byte gives one event of keycode and press flag.
// Output stream: one transfer per event, keycode in tdata, press flag in tuser.
//
// The event of a byte is offered in the cycle after its transfer, read from
// the table's registered read port, which doubles as the output register.
// Throughput is one item per cycle unless the receiver stalls;
// a table write takes effect for a byte transferred in the next cycle.
//
// Reset clears the prefix flags, the pause phase and every table entry's
// valid bit at once, so all entries read as zero until written; no clearing
// pass is needed. When the receiver stalls, the pending event holds and
// tready drops until it is taken, so nothing is lost; tready stays high
// while the output register is empty or being drained.
`default_nettype none
module ps2_scancode_translator
    import ps2st_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [23:0] i_s_tdata,   // scan_byte[7:0], table_index[15:8], table_value[23:16]
    input  wire logic        i_s_tuser,   // mode
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // key_code
    output logic             o_m_tuser    // pressed
);

    logic        s_fire;
    t_dec_result dec;
    logic        r_out_valid;
    logic        r_pressed;

    assign o_s_tready = ~r_out_valid | i_m_tready;
    assign s_fire     = i_s_tvalid & o_s_tready;

    ps2st_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (s_fire),
        .i_mode      (i_s_tuser),
        .i_scan_byte (i_s_tdata[7:0]),
        .o_result    (dec)
    );

    ps2st_key_table u_key_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (s_fire & (i_s_tuser == MODE_WRITE)),
        .i_waddr (i_s_tdata[15:8]),
        .i_wdata (i_s_tdata[23:16]),
        .i_re    (s_fire & dec.emit),
        .i_raddr (dec.code),
        .o_rdata (o_m_tdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= dec.emit;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire && dec.emit) begin
            r_pressed <= dec.pressed;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_pressed;

    // an event appears only from an emitting byte or from a stalled earlier event
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(s_fire && dec.emit))
        else $error("output event without an emitting input byte");

    // a table write never produces an event
    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_tuser == MODE_WRITE && (!o_m_tvalid || i_m_tready))
        |=> !o_m_tvalid)
        else $error("table write produced an event");

    // a release prefix followed directly by a plain byte reports a release
    a_release_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && i_s_tuser == MODE_SCAN && i_s_tdata[7:0] == SC_RELEASE)
        ##1 (s_fire && dec.emit) |=> !o_m_tuser)
        else $error("release prefix lost");

endmodule
`default_nettype wire
